// ===== rtl/core/udpcs_pkg.sv =====
// Shared constants, types and helpers of the UDP/IPv6 checksum generator.
package udpcs_pkg;

  localparam int unsigned MAX_PAYLOAD      = 65527;
  localparam int unsigned UDP_HEADER_BYTES = 8;

  localparam int COUNT_W  = 17;
  localparam int ACC_W    = 32;
  localparam int PART_W   = 18;
  localparam int STATIC_W = 21;
  localparam int TOTAL_W  = 33;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // register indexes (paddr[5:3])
  localparam logic [IDX_W-1:0] REG_SRC_ADDR_HIGH = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_ADDR_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_ADDR_HIGH = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_ADDR_LOW  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SRC_PORT      = 3'd4;
  localparam logic [IDX_W-1:0] REG_DST_PORT      = 3'd5;
  localparam logic [IDX_W-1:0] REG_NEXT_HEADER   = 3'd6;

  localparam logic [7:0] NEXT_HEADER_RESET = 8'd17;

  // one queue entry: a word to add, and on close the length and flag
  typedef struct packed {
    logic        close;
    logic        too_long;
    logic [15:0] word;
    logic [15:0] udp_length;
  } entry_t;

  // plain sum of the four 16-bit words of a 64-bit quantity
  function automatic logic [PART_W-1:0] sum4(input logic [63:0] v);
    logic [PART_W-1:0] s;
    s = PART_W'(v[63:48]) + PART_W'(v[47:32]) + PART_W'(v[31:16]) + PART_W'(v[15:0]);
    return s;
  endfunction

endpackage

// ===== rtl/core/udpcs_cfg.sv =====
// APB register file and registered sum of the static pseudo-header words.
module udpcs_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [udpcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [udpcs_pkg::DATA_W-1:0]   pwdata,
  output logic [udpcs_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output logic [udpcs_pkg::STATIC_W-1:0] static_sum
);

  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;
  logic [63:0] dst_addr_high;
  logic [63:0] dst_addr_low;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  next_header;

  logic                          wr_en;
  logic [udpcs_pkg::IDX_W-1:0]   idx;

  logic [udpcs_pkg::PART_W-1:0] part_sh, part_sl, part_dh, part_dl, part_misc;

  assign pready = 1'b1;
  assign idx    = paddr[udpcs_pkg::ADDR_W-1:udpcs_pkg::ADDR_W-udpcs_pkg::IDX_W];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_addr_high <= '0;
      src_addr_low  <= '0;
      dst_addr_high <= '0;
      dst_addr_low  <= '0;
      src_port      <= '0;
      dst_port      <= '0;
      next_header   <= udpcs_pkg::NEXT_HEADER_RESET;
    end else if (wr_en) begin
      unique case (idx)
        udpcs_pkg::REG_SRC_ADDR_HIGH: src_addr_high <= pwdata;
        udpcs_pkg::REG_SRC_ADDR_LOW:  src_addr_low  <= pwdata;
        udpcs_pkg::REG_DST_ADDR_HIGH: dst_addr_high <= pwdata;
        udpcs_pkg::REG_DST_ADDR_LOW:  dst_addr_low  <= pwdata;
        udpcs_pkg::REG_SRC_PORT:      src_port      <= pwdata[15:0];
        udpcs_pkg::REG_DST_PORT:      dst_port      <= pwdata[15:0];
        udpcs_pkg::REG_NEXT_HEADER:   next_header   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      udpcs_pkg::REG_SRC_ADDR_HIGH: prdata = src_addr_high;
      udpcs_pkg::REG_SRC_ADDR_LOW:  prdata = src_addr_low;
      udpcs_pkg::REG_DST_ADDR_HIGH: prdata = dst_addr_high;
      udpcs_pkg::REG_DST_ADDR_LOW:  prdata = dst_addr_low;
      udpcs_pkg::REG_SRC_PORT:      prdata = {48'h0, src_port};
      udpcs_pkg::REG_DST_PORT:      prdata = {48'h0, dst_port};
      udpcs_pkg::REG_NEXT_HEADER:   prdata = {56'h0, next_header};
      default:                      prdata = '0;
    endcase
  end

  // two-stage tree, free running: registered partial sums, then registered static_sum
  always_ff @(posedge clk) begin
    part_sh    <= udpcs_pkg::sum4(src_addr_high);
    part_sl    <= udpcs_pkg::sum4(src_addr_low);
    part_dh    <= udpcs_pkg::sum4(dst_addr_high);
    part_dl    <= udpcs_pkg::sum4(dst_addr_low);
    part_misc  <= udpcs_pkg::PART_W'(src_port) + udpcs_pkg::PART_W'(dst_port)
                + udpcs_pkg::PART_W'(next_header);
    static_sum <= udpcs_pkg::STATIC_W'(part_sh) + udpcs_pkg::STATIC_W'(part_sl)
                + udpcs_pkg::STATIC_W'(part_dh) + udpcs_pkg::STATIC_W'(part_dl)
                + udpcs_pkg::STATIC_W'(part_misc);
  end

endmodule

// ===== rtl/core/udpcs_front.sv =====
// Front end: pairs payload bytes into words, counts bytes, closes datagrams.
module udpcs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            payload_byte,
  input  logic                  byte_present,
  input  logic                  last,
  input  logic                  q_full,
  output logic                  q_push,
  output udpcs_pkg::entry_t     q_entry
);

  logic [7:0]                      held_byte, held_byte_next;
  logic                            odd_pending, odd_pending_next;
  logic [udpcs_pkg::COUNT_W-1:0]   byte_count, byte_count_next;
  logic                            overflow_seen, overflow_now;
  logic                            pair;
  logic [15:0]                     word;
  logic [udpcs_pkg::COUNT_W:0]     len_full;
  logic                            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    held_byte_next   = held_byte;
    odd_pending_next = odd_pending;
    byte_count_next  = byte_count;
    overflow_now     = overflow_seen;
    pair             = 1'b0;
    word             = '0;
    if (byte_present) begin
      if (byte_count >= udpcs_pkg::COUNT_W'(udpcs_pkg::MAX_PAYLOAD)) begin
        overflow_now = 1'b1;
      end
      if (!overflow_now) begin
        if (odd_pending) begin
          pair             = 1'b1;
          word             = {held_byte, payload_byte};
          odd_pending_next = 1'b0;
        end else begin
          held_byte_next   = payload_byte;
          odd_pending_next = 1'b1;
        end
      end
      if (byte_count != '1) begin
        byte_count_next = byte_count + 1'b1;
      end
    end
    // odd byte left at close goes out zero padded
    if (!pair && odd_pending_next) begin
      word = {held_byte_next, 8'h00};
    end
  end

  assign len_full = (udpcs_pkg::COUNT_W+1)'(byte_count_next)
                  + (udpcs_pkg::COUNT_W+1)'(udpcs_pkg::UDP_HEADER_BYTES);

  always_comb begin
    q_entry.close      = last;
    q_entry.too_long   = overflow_now;
    q_entry.word       = word;
    q_entry.udp_length = (len_full > (udpcs_pkg::COUNT_W+1)'(16'hffff)) ? 16'hffff
                                                                       : len_full[15:0];
  end

  assign q_push = accept && (pair || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte     <= '0;
      odd_pending   <= 1'b0;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last) begin
        held_byte     <= '0;
        odd_pending   <= 1'b0;
        byte_count    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        held_byte     <= held_byte_next;
        odd_pending   <= odd_pending_next;
        byte_count    <= byte_count_next;
        overflow_seen <= overflow_now;
      end
    end
  end

endmodule

// ===== rtl/core/udpcs_queue.sv =====
// Short FIFO of word and close entries between front and back ends.
module udpcs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  udpcs_pkg::entry_t entry_in,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output udpcs_pkg::entry_t head
);

  udpcs_pkg::entry_t                 slots [udpcs_pkg::QUEUE_DEPTH];
  logic [udpcs_pkg::QUEUE_AW-1:0]    wr_ptr, rd_ptr;
  logic [udpcs_pkg::QUEUE_CW-1:0]    fill;

  assign full       = (fill == udpcs_pkg::QUEUE_CW'(udpcs_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/udpcs_back.sv =====
// Back end: accumulates words, adds pseudo-header, folds and complements.
module udpcs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  udpcs_pkg::entry_t              head,
  output logic                           pop,
  input  logic [udpcs_pkg::STATIC_W-1:0] static_sum,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    checksum_value,
  output logic [15:0]                    udp_length,
  output logic                           too_long
);

  logic [udpcs_pkg::ACC_W-1:0]   acc;
  logic [udpcs_pkg::ACC_W-1:0]   fin_sum;
  logic [15:0]                   fin_len;
  logic                          fin_long, fin_valid;
  logic [udpcs_pkg::TOTAL_W-1:0] tot_sum;
  logic [15:0]                   tot_len;
  logic                          tot_long, tot_valid;

  logic                          out_free, tot_free, fin_free, tot_move, fin_move;
  logic [udpcs_pkg::ACC_W-1:0]   acc_plus;
  logic [17:0]                   fold1;
  logic [16:0]                   fold2;
  logic [15:0]                   fold3;

  assign out_free = !out_valid || out_ready;
  assign tot_move = tot_valid && out_free;
  assign tot_free = !tot_valid || out_free;
  assign fin_move = fin_valid && tot_free;
  assign fin_free = !fin_valid || tot_free;
  assign pop      = head_valid && (!head.close || fin_free);

  assign acc_plus = acc + udpcs_pkg::ACC_W'(head.word);

  // end-around carry fold of the 33-bit total
  assign fold1 = 18'(tot_sum[udpcs_pkg::TOTAL_W-1:16]) + 18'(tot_sum[15:0]);
  assign fold2 = 17'(fold1[17:16]) + 17'(fold1[15:0]);
  assign fold3 = fold2[15:0] + 16'(fold2[16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fin_valid <= 1'b0;
      tot_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        acc <= head.close ? '0 : acc_plus;
      end
      if (fin_free) begin
        fin_valid <= pop && head.close;
      end
      if (tot_free) begin
        tot_valid <= fin_valid;
      end
      if (out_free) begin
        out_valid <= tot_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.close && fin_free) begin
      fin_sum  <= acc_plus + udpcs_pkg::ACC_W'({head.udp_length, 1'b0});
      fin_len  <= head.udp_length;
      fin_long <= head.too_long;
    end
    if (fin_move) begin
      tot_sum  <= udpcs_pkg::TOTAL_W'(fin_sum) + udpcs_pkg::TOTAL_W'(static_sum);
      tot_len  <= fin_len;
      tot_long <= fin_long;
    end
    if (tot_move) begin
      checksum_value <= tot_long ? 16'h0000 : ~fold3;
      udp_length     <= tot_len;
      too_long       <= tot_long;
    end
  end

endmodule

// ===== rtl/core/udp_ipv6_checksum_generator_top.sv =====
// Top level of the UDP-over-IPv6 checksum generator.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | payload_byte, byte_present, last
//  out      | out_valid / out_ready| checksum_value, udp_length, too_long
//  config   | APB psel/penable     | paddr (8 bytes per register), pwdata, prdata
//
// One request per clock while in_ready is high; each byte pair costs one add in the back end accumulator.
// A closing request passes its queue slot, the finish sum, the pseudo-header
// total and then the folded result register before its result is offered.
// rst is synchronous; after reset or a write the pseudo-header sum settles through the partial sums, then static_sum.
// A four-entry queue parts front and back; input keeps flowing while a result
// waits, and in_ready falls only once that queue is full.
module udp_ipv6_checksum_generator_top (
  input  logic                         clk,
  input  logic                         rst,
  // config
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [udpcs_pkg::ADDR_W-1:0] paddr,
  input  logic [udpcs_pkg::DATA_W-1:0] pwdata,
  output logic [udpcs_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   payload_byte,
  input  logic                         byte_present,
  input  logic                         last,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  checksum_value,
  output logic [15:0]                  udp_length,
  output logic                         too_long
);

  logic [udpcs_pkg::STATIC_W-1:0] static_sum;   // addresses, ports, next header
  logic                           q_full, q_push, q_pop, q_head_valid;
  udpcs_pkg::entry_t              q_entry, q_head;

  udpcs_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .static_sum (static_sum)
  );

  // byte pairing, counting and overlong detection
  udpcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .byte_present (byte_present),
    .last         (last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  udpcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .entry_in   (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // summing, pseudo-header, fold and result register
  udpcs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_head_valid),
    .head           (q_head),
    .pop            (q_pop),
    .static_sum     (static_sum),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .checksum_value (checksum_value),
    .udp_length     (udp_length),
    .too_long       (too_long)
  );

  // front never writes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  // overlong datagram: checksum forced to zero, length saturated
  a_too_long_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_long) |-> (checksum_value == 16'h0000 && udp_length == 16'hffff))
    else $error("overlong result fields wrong");

  // a result always covers at least the UDP header
  a_min_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (udp_length >= 16'(udpcs_pkg::UDP_HEADER_BYTES)))
    else $error("udp_length below header size");

endmodule
